// ----- rtl/bracket_balance_checker_assert.svh -----
// Assertion macros used by the bracket balance checker RTL (bbc_back).
// In synthesis the macros expand to nothing.
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define BBC_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("bracket balance checker assertion failed");
`define BBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("bracket balance checker assertion failed");
`else
`define BBC_ASSERT(lbl, clk_s, rstn_s, prop)
`define BBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ----- rtl/bbc_pkg.sv -----
`default_nettype none

package bbc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

    localparam int DEPTH_FIELD_MAX = 127;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_code_t;

    typedef struct packed {
        op_code_t code;
        kind_t    kind;
        logic     last;
    } op_t;

endpackage

`default_nettype wire

// ----- rtl/bbc_front.sv -----
`default_nettype none

module bbc_front
(
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_byte,
    input  wire logic        last_char,
    input  wire logic        queue_full,
    output logic             queue_write,
    output bbc_pkg::op_t     queue_op
);
    import bbc_pkg::*;

    // Decode one character into a stack operation.
    always_comb
    begin
        queue_op.last = last_char;
        queue_op.code = OP_NONE;
        queue_op.kind = KIND_ROUND;
        unique case (char_byte)
            CHAR_OPEN_ROUND:
            begin
                queue_op.code = OP_PUSH;
                queue_op.kind = KIND_ROUND;
            end
            CHAR_OPEN_SQUARE:
            begin
                queue_op.code = OP_PUSH;
                queue_op.kind = KIND_SQUARE;
            end
            CHAR_OPEN_CURLY:
            begin
                queue_op.code = OP_PUSH;
                queue_op.kind = KIND_CURLY;
            end
            CHAR_CLOSE_ROUND:
            begin
                queue_op.code = OP_POP;
                queue_op.kind = KIND_ROUND;
            end
            CHAR_CLOSE_SQUARE:
            begin
                queue_op.code = OP_POP;
                queue_op.kind = KIND_SQUARE;
            end
            CHAR_CLOSE_CURLY:
            begin
                queue_op.code = OP_POP;
                queue_op.kind = KIND_CURLY;
            end
            default:
            begin
                queue_op.code = OP_NONE;
                queue_op.kind = KIND_ROUND;
            end
        endcase
    end

    assign char_stall  = queue_full;
    assign queue_write = char_valid && !queue_full;

endmodule

`default_nettype wire

// ----- rtl/bbc_queue.sv -----
`default_nettype none

module bbc_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          write_en,
    input  wire bbc_pkg::op_t  write_op,
    output logic               full,
    input  wire logic          read_en,
    output logic               not_empty,
    output bbc_pkg::op_t       read_op
);
    import bbc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    op_t           slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (write_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (read_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (write_en && !read_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (read_en && !write_en)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            slot_reg[wr_ptr_reg] <= write_op;
        end
    end

    assign full      = (fill_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign read_op   = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/bbc_back.sv -----
`default_nettype none
`include "bracket_balance_checker_assert.svh"

module bbc_back
#(
    parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          op_valid,
    input  wire bbc_pkg::op_t  op,
    output logic               op_take,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic               verdict_valid,
    output logic               balanced,
    output logic               overflowed,
    output logic [6:0]         nesting_depth
);
    import bbc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Entries below the top two live in the memory; the top and the one
    // under it are held in registers so a pop never waits on a read.
    kind_t         kind_mem [STACK_DEPTH];
    kind_t         top_reg;
    kind_t         top_next;
    kind_t         under_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_after;
    logic          error_reg;
    logic          error_next;
    logic          error_after;
    logic          overflow_reg;
    logic          overflow_next;
    logic          overflow_after;

    logic          advance;
    logic          issue;
    logic          is_push;
    logic          is_pop;
    logic          stack_full;
    logic          stack_empty;
    logic          push_ok;
    logic          pop_ok;
    logic          mismatch;

    logic          result_valid_reg;
    logic          verdict_valid_reg;
    logic          balanced_reg;
    logic          overflowed_reg;
    logic [6:0]    nesting_depth_reg;

    assign advance     = !result_valid_reg || !result_stall;
    assign issue       = op_valid && advance;
    assign op_take     = issue;

    assign is_push     = (op.code == OP_PUSH);
    assign is_pop      = (op.code == OP_POP);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign push_ok     = issue && is_push && !stack_full;
    assign pop_ok      = issue && is_pop && !stack_empty;
    assign mismatch    = pop_ok && (top_reg != op.kind);

    always_comb
    begin
        count_after = count_reg;
        top_next    = top_reg;
        if (push_ok)
        begin
            count_after = count_reg + 1'b1;
            top_next    = op.kind;
        end
        else if (pop_ok)
        begin
            count_after = count_reg - 1'b1;
            top_next    = under_reg;
        end
        error_after    = error_reg || (is_push && stack_full) || (is_pop && stack_empty)
                         || mismatch;
        overflow_after = overflow_reg || (is_push && stack_full);

        count_next    = count_reg;
        error_next    = error_reg;
        overflow_next = overflow_reg;
        if (issue)
        begin
            count_next    = op.last ? '0 : count_after;
            error_next    = op.last ? 1'b0 : error_after;
            overflow_next = op.last ? 1'b0 : overflow_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            error_reg        <= 1'b0;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            error_reg    <= error_next;
            overflow_reg <= overflow_next;
            if (advance)
            begin
                result_valid_reg <= op_valid;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            verdict_valid_reg <= op.last;
            balanced_reg      <= op.last && !error_after && (count_after == '0);
            overflowed_reg    <= overflow_after;
            nesting_depth_reg <= (32'(count_after) > 32'(DEPTH_FIELD_MAX))
                                 ? 7'(DEPTH_FIELD_MAX) : 7'(count_after);
        end
    end

    // Top-of-stack registers and the memory behind them.
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (push_ok)
        begin
            under_reg <= top_reg;
        end
        else if (pop_ok)
        begin
            under_reg <= kind_mem[AW'(count_reg - CW'(3))];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok && !stack_empty)
        begin
            kind_mem[AW'(count_reg - 1'b1)] <= top_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign verdict_valid = verdict_valid_reg;
    assign balanced      = balanced_reg;
    assign overflowed    = overflowed_reg;
    assign nesting_depth = nesting_depth_reg;

    `BBC_ASSERT(count_in_range, clk, rst_n, count_reg <= CW'(STACK_DEPTH))
    `BBC_ASSERT(overflow_implies_error, clk, rst_n, !overflow_reg || error_reg)
    `BBC_ASSERT_NEXT(last_clears_state, clk, rst_n, issue && op.last,
                     count_reg == '0 && !error_reg && !overflow_reg)

endmodule

`default_nettype wire

// ----- rtl/bracket_balance_checker.sv -----
// Path: an accepted item is written into the queue, then into the result register in
// bbc_back when that stage can advance, and its result is taken from there.
// Throughput: one item per cycle while the queue is not full; result_stall can fill it.
// Reset (rst_n, asynchronous, active low) empties the queue and the result stage
// and clears the depth count and the error flags; the stack memory is not cleared.
`default_nettype none

module bracket_balance_checker
#(
    parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_byte,
    input  wire logic        last_char,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             verdict_valid,
    output logic             balanced,
    output logic             overflowed,
    output logic [6:0]       nesting_depth
);
    import bbc_pkg::*;

    // The front end turns each incoming character into a push, a pop or no
    // operation and writes it into a short queue. The queue decouples the
    // input side from the stack engine, so a stalled output only holds off the
    // input once the queue has filled.
    op_t  front_op;
    logic front_write;
    logic queue_full;
    logic queue_not_empty;
    op_t  queue_op;
    logic queue_read;

    bbc_front u_front
    (
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_byte   (char_byte),
        .last_char   (last_char),
        .queue_full  (queue_full),
        .queue_write (front_write),
        .queue_op    (front_op)
    );

    bbc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .write_en  (front_write),
        .write_op  (front_op),
        .full      (queue_full),
        .read_en   (queue_read),
        .not_empty (queue_not_empty),
        .read_op   (queue_op)
    );

    // The back end keeps the top two stack entries in registers and the rest
    // in a memory, so a pop never waits on a memory read. Its result
    // register doubles as the output stage: a new item is taken whenever the
    // result register is empty or is being taken in the same cycle.
    bbc_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (queue_not_empty),
        .op            (queue_op),
        .op_take       (queue_read),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .verdict_valid (verdict_valid),
        .balanced      (balanced),
        .overflowed    (overflowed),
        .nesting_depth (nesting_depth)
    );

endmodule

`default_nettype wire
